// ===== sv/adcema_pkg.sv =====
// adcema_pkg: shared types and constants for the ADC oversample / EMA filter.
// Used by adcema_ctrl, adcema_dp and adc_oversample_ema_filter. No dependencies.
package adcema_pkg;

  localparam int SAMPLES_PER_BLOCK_DEF = 16;

  localparam int SAMPLE_W = 12;
  localparam int MV_W     = 13;
  localparam int ALPHA_W  = 16;
  localparam int VREF_W   = 13;
  localparam int STATE_W  = 28;
  localparam int FRAC_W   = 16;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] REG_ALPHA = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_VREF  = 1'd1;

  localparam logic [ALPHA_W-1:0] ALPHA_RESET = 16'd6554;
  localparam logic [VREF_W-1:0]  VREF_RESET  = 13'd3300;

  localparam int ADC_FULL_SCALE = 4095;
  localparam int STEP_W         = 4;

  typedef enum logic [2:0] {
    S_ACC,
    S_DIV,
    S_MUL,
    S_WB,
    S_OUT
  } state_e;

  typedef enum logic [2:0] {
    OP_EMA_V,
    OP_EMA_C,
    OP_MV_RAW_V,
    OP_MV_RAW_C,
    OP_MV_ST_V,
    OP_MV_ST_C
  } op_e;

  typedef struct packed {
    logic frame_en;
    logic block_end;
    logic div_step;
    logic mul_en;
    logic wb_en;
    logic ema_load;
    logic out_load;
    op_e  op;
  } dp_cmd_t;

endpackage

// ===== sv/adcema_ctrl.sv =====
// adcema_ctrl: sequencer for frame counting, block average division, shared
// multiplier ops and result handoff. Depends on adcema_pkg.
module adcema_ctrl #(
  parameter int SamplesPerBlock = adcema_pkg::SAMPLES_PER_BLOCK_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output adcema_pkg::dp_cmd_t cmd_o
);
  import adcema_pkg::*;

  localparam int CNT_W = $clog2(SamplesPerBlock + 1);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [STEP_W-1:0] step_q, step_d;
  logic              started_q, started_d;
  logic              out_valid_q, out_valid_d;
  logic              last_frame;
  logic              accept;

  assign last_frame = (cnt_q == CNT_W'(SamplesPerBlock - 1));
  assign accept     = (state_q == S_ACC) && in_valid_i;

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_ACC: begin
        if (accept && last_frame) state_d = S_DIV;
      end
      S_DIV: state_d = S_MUL;
      S_MUL: state_d = S_WB;
      S_WB: begin
        if (op_e'(step_q[2:0]) == OP_MV_ST_C) state_d = S_OUT;
        else                                  state_d = S_MUL;
      end
      S_OUT: begin
        if (!out_valid_q || !out_stall_i) state_d = S_ACC;
      end
      default: state_d = S_ACC;
    endcase
  end

  // outputs
  always_comb begin
    cmd_o           = '0;
    cmd_o.op        = op_e'(step_q[2:0]);
    cmd_o.ema_load  = !started_q;
    in_stall_o      = 1'b1;
    case (state_q)
      S_ACC: begin
        in_stall_o      = 1'b0;
        cmd_o.frame_en  = in_valid_i;
        cmd_o.block_end = in_valid_i && last_frame;
      end
      S_DIV:   cmd_o.div_step = 1'b1;
      S_MUL:   cmd_o.mul_en   = 1'b1;
      S_WB:    cmd_o.wb_en    = 1'b1;
      S_OUT:   cmd_o.out_load = !out_valid_q || !out_stall_i;
      default: cmd_o = cmd_o;
    endcase
  end

  always_comb begin
    cnt_d       = cnt_q;
    step_d      = step_q;
    started_d   = started_q;
    out_valid_d = out_valid_q;
    if (cmd_o.frame_en) cnt_d = last_frame ? '0 : cnt_q + CNT_W'(1);
    case (state_q)
      S_WB: begin
        step_d = (op_e'(step_q[2:0]) == OP_MV_ST_C) ? '0 : step_q + STEP_W'(1);
        if (op_e'(step_q[2:0]) == OP_EMA_C) started_d = 1'b1;
      end
      default: step_d = step_q;
    endcase
    if (out_valid_q && !out_stall_i) out_valid_d = 1'b0;
    if (cmd_o.out_load)              out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_ACC;
      cnt_q       <= '0;
      step_q      <= '0;
      started_q   <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      step_q      <= step_d;
      started_q   <= started_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// ===== sv/adcema_dp.sv =====
// adcema_dp: accumulators, reciprocal-multiply block divider, shared multiplier, EMA
// state, mV scaling and result registers. Depends on adcema_pkg.
module adcema_dp #(
  parameter int SamplesPerBlock = adcema_pkg::SAMPLES_PER_BLOCK_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  adcema_pkg::dp_cmd_t                   cmd_i,
  input  logic                                  cfg_we_i,
  input  logic [adcema_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [adcema_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic [adcema_pkg::SAMPLE_W-1:0]       vbat_sample_i,
  input  logic [adcema_pkg::SAMPLE_W-1:0]       current_sample_i,
  output logic [adcema_pkg::SAMPLE_W-1:0]       vbat_raw_o,
  output logic [adcema_pkg::SAMPLE_W-1:0]       current_raw_o,
  output logic [adcema_pkg::SAMPLE_W-1:0]       vbat_filtered_raw_o,
  output logic [adcema_pkg::SAMPLE_W-1:0]       current_filtered_raw_o,
  output logic [adcema_pkg::MV_W-1:0]           vbat_mv_o,
  output logic [adcema_pkg::MV_W-1:0]           current_mv_o,
  output logic [adcema_pkg::MV_W-1:0]           vbat_filtered_mv_o,
  output logic [adcema_pkg::MV_W-1:0]           current_filtered_mv_o
);
  import adcema_pkg::*;

  localparam int SUM_W  = $clog2(SamplesPerBlock * ADC_FULL_SCALE + 1);
  localparam int DIV_SH = SUM_W + $clog2(SamplesPerBlock);
  localparam int RCP_W  = SUM_W + 1;
  localparam int QUO_W  = SUM_W + RCP_W;
  localparam int MA_W   = STATE_W + 1;
  localparam int MB_W   = ALPHA_W + 1;
  localparam int PROD_W = MA_W + MB_W;
  localparam int X_W    = VREF_W + SAMPLE_W;
  localparam int HI_W   = X_W - SAMPLE_W;
  localparam logic [RCP_W-1:0] DIV_RCP =
    RCP_W'((longint'(1) << DIV_SH) / longint'(SamplesPerBlock) + longint'(1));
  localparam logic [HI_W:0] FS1 = (HI_W+1)'(ADC_FULL_SCALE);
  localparam logic [HI_W:0] FS2 = (HI_W+1)'(2 * ADC_FULL_SCALE);
  localparam logic [HI_W:0] FS3 = (HI_W+1)'(3 * ADC_FULL_SCALE);

  logic [ALPHA_W-1:0]  alpha_q;
  logic [VREF_W-1:0]   vref_q;
  logic [SUM_W-1:0]    sum_v_q, sum_c_q, blk_v_q, blk_c_q;
  logic [SAMPLE_W-1:0] avg_v_q, avg_c_q;
  logic [STATE_W-1:0]  st_v_q, st_c_q;
  logic signed [PROD_W-1:0] prod_q;
  logic [MV_W-1:0]     mv_rv_q, mv_rc_q, mv_sv_q, mv_sc_q;

  logic [SUM_W-1:0]    sum_v_d, sum_c_d;
  logic [QUO_W-1:0]    quo_v, quo_c;
  logic signed [MA_W-1:0] mul_a;
  logic signed [MB_W-1:0] mul_b;
  logic [SAMPLE_W-1:0] ema_avg;
  logic [STATE_W-1:0]  ema_st, ema_new;
  logic [X_W-1:0]      mv_x;
  logic [HI_W-1:0]     mv_hi;
  logic [HI_W:0]       mv_r;
  logic [1:0]          mv_c;
  logic [HI_W:0]       mv_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_q <= ALPHA_RESET;
      vref_q  <= VREF_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_ALPHA: alpha_q <= cfg_data_i[ALPHA_W-1:0];
        REG_VREF:  vref_q  <= cfg_data_i[VREF_W-1:0];
        default:   alpha_q <= alpha_q;
      endcase
    end
  end

  // accumulate; the completing frame moves the sum into the divider
  assign sum_v_d = sum_v_q + SUM_W'(vbat_sample_i);
  assign sum_c_d = sum_c_q + SUM_W'(current_sample_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_v_q <= '0;
      sum_c_q <= '0;
    end else if (cmd_i.frame_en) begin
      sum_v_q <= cmd_i.block_end ? '0 : sum_v_d;
      sum_c_q <= cmd_i.block_end ? '0 : sum_c_d;
    end
  end

  // floor(sum / block length) as a multiply by the rounded-up reciprocal,
  // exact over the whole sum range
  assign quo_v = QUO_W'(blk_v_q) * QUO_W'(DIV_RCP);
  assign quo_c = QUO_W'(blk_c_q) * QUO_W'(DIV_RCP);

  always_ff @(posedge clk_i) begin
    if (cmd_i.block_end) begin
      blk_v_q <= sum_v_d;
      blk_c_q <= sum_c_d;
    end else if (cmd_i.div_step) begin
      avg_v_q <= quo_v[DIV_SH +: SAMPLE_W];
      avg_c_q <= quo_c[DIV_SH +: SAMPLE_W];
    end
  end

  // shared multiplier operand select
  always_comb begin
    ema_avg = (cmd_i.op == OP_EMA_C) ? avg_c_q : avg_v_q;
    ema_st  = (cmd_i.op == OP_EMA_C) ? st_c_q  : st_v_q;
    mul_b   = MB_W'(vref_q);
    case (cmd_i.op)
      OP_EMA_V, OP_EMA_C: begin
        mul_a = $signed({1'b0, ema_avg, {FRAC_W{1'b0}}}) - $signed({1'b0, ema_st});
        mul_b = $signed({1'b0, alpha_q});
      end
      OP_MV_RAW_V: mul_a = $signed({1'b0, avg_v_q, {FRAC_W{1'b0}}});
      OP_MV_RAW_C: mul_a = $signed({1'b0, avg_c_q, {FRAC_W{1'b0}}});
      OP_MV_ST_V:  mul_a = $signed({1'b0, st_v_q});
      OP_MV_ST_C:  mul_a = $signed({1'b0, st_c_q});
      default:     mul_a = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) prod_q <= mul_a * mul_b;
  end

  // EMA step: arithmetic shift floors, result wraps to the state width
  assign ema_new = ema_st + prod_q[FRAC_W +: STATE_W];

  // x / 4095 with x = hi*4096 + lo: quotient is hi + floor((hi + lo) / 4095)
  assign mv_x  = prod_q[FRAC_W +: X_W];
  assign mv_hi = mv_x[X_W-1:SAMPLE_W];
  assign mv_r  = (HI_W+1)'(mv_hi) + (HI_W+1)'(mv_x[SAMPLE_W-1:0]);
  always_comb begin
    if (mv_r >= FS3)      mv_c = 2'd3;
    else if (mv_r >= FS2) mv_c = 2'd2;
    else if (mv_r >= FS1) mv_c = 2'd1;
    else                  mv_c = 2'd0;
  end
  assign mv_q = (HI_W+1)'(mv_hi) + (HI_W+1)'(mv_c);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wb_en) begin
      case (cmd_i.op)
        OP_EMA_V:    st_v_q  <= cmd_i.ema_load ? {avg_v_q, {FRAC_W{1'b0}}} : ema_new;
        OP_EMA_C:    st_c_q  <= cmd_i.ema_load ? {avg_c_q, {FRAC_W{1'b0}}} : ema_new;
        OP_MV_RAW_V: mv_rv_q <= mv_q[MV_W-1:0];
        OP_MV_RAW_C: mv_rc_q <= mv_q[MV_W-1:0];
        OP_MV_ST_V:  mv_sv_q <= mv_q[MV_W-1:0];
        OP_MV_ST_C:  mv_sc_q <= mv_q[MV_W-1:0];
        default:     mv_rv_q <= mv_rv_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      vbat_raw_o             <= avg_v_q;
      current_raw_o          <= avg_c_q;
      vbat_filtered_raw_o    <= st_v_q[STATE_W-1:FRAC_W];
      current_filtered_raw_o <= st_c_q[STATE_W-1:FRAC_W];
      vbat_mv_o              <= mv_rv_q;
      current_mv_o           <= mv_rc_q;
      vbat_filtered_mv_o     <= mv_sv_q;
      current_filtered_mv_o  <= mv_sc_q;
    end
  end

endmodule

// ===== sv/adc_oversample_ema_filter.sv =====
// Two-channel ADC oversampler with per-channel EMA and mV scaling.
// A frame that does not end a block is accepted whenever the input is not stalled. The
// frame ending a block starts the work: the reciprocal-multiply block average, six ops on
// the shared multiplier, then the result load; input stalls during that time and while a
// result waits. Reset (async, active low) clears sums, frame count, filter start flag and
// output valid and resets alpha and vref. Depends on adcema_pkg, adcema_ctrl, adcema_dp.
module adc_oversample_ema_filter #(
  parameter int SamplesPerBlock = adcema_pkg::SAMPLES_PER_BLOCK_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [adcema_pkg::SAMPLE_W-1:0]   vbat_sample_i,
  input  logic [adcema_pkg::SAMPLE_W-1:0]   current_sample_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [adcema_pkg::SAMPLE_W-1:0]   vbat_raw_o,
  output logic [adcema_pkg::SAMPLE_W-1:0]   current_raw_o,
  output logic [adcema_pkg::SAMPLE_W-1:0]   vbat_filtered_raw_o,
  output logic [adcema_pkg::SAMPLE_W-1:0]   current_filtered_raw_o,
  output logic [adcema_pkg::MV_W-1:0]       vbat_mv_o,
  output logic [adcema_pkg::MV_W-1:0]       current_mv_o,
  output logic [adcema_pkg::MV_W-1:0]       vbat_filtered_mv_o,
  output logic [adcema_pkg::MV_W-1:0]       current_filtered_mv_o,
  input  logic                              cfg_we_i,
  input  logic [adcema_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [adcema_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import adcema_pkg::*;

  dp_cmd_t cmd;

  adcema_ctrl #(
    .SamplesPerBlock(SamplesPerBlock)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .cmd_o      (cmd)
  );

  adcema_dp #(
    .SamplesPerBlock(SamplesPerBlock)
  ) u_dp (
    .clk_i                 (clk_i),
    .rst_ni                (rst_ni),
    .cmd_i                 (cmd),
    .cfg_we_i              (cfg_we_i),
    .cfg_idx_i             (cfg_idx_i),
    .cfg_data_i            (cfg_data_i),
    .vbat_sample_i         (vbat_sample_i),
    .current_sample_i      (current_sample_i),
    .vbat_raw_o            (vbat_raw_o),
    .current_raw_o         (current_raw_o),
    .vbat_filtered_raw_o   (vbat_filtered_raw_o),
    .current_filtered_raw_o(current_filtered_raw_o),
    .vbat_mv_o             (vbat_mv_o),
    .current_mv_o          (current_mv_o),
    .vbat_filtered_mv_o    (vbat_filtered_mv_o),
    .current_filtered_mv_o (current_filtered_mv_o)
  );

endmodule

// ===== dv/adcema_checker.sv =====
// adcema_checker: watches the frame, result and register ports of adc_oversample_ema_filter,
// predicts each block result (averages, Q12.16 EMA, mV scaling) and compares field by field.
// Depends on adcema_pkg.
module adcema_checker
  import adcema_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_stall_i,
  input  logic [SAMPLE_W-1:0]   vbat_sample_i,
  input  logic [SAMPLE_W-1:0]   current_sample_i,
  input  logic                  out_valid_i,
  input  logic                  out_stall_i,
  input  logic [SAMPLE_W-1:0]   vbat_raw_i,
  input  logic [SAMPLE_W-1:0]   current_raw_i,
  input  logic [SAMPLE_W-1:0]   vbat_filtered_raw_i,
  input  logic [SAMPLE_W-1:0]   current_filtered_raw_i,
  input  logic [MV_W-1:0]       vbat_mv_i,
  input  logic [MV_W-1:0]       current_mv_i,
  input  logic [MV_W-1:0]       vbat_filtered_mv_i,
  input  logic [MV_W-1:0]       current_filtered_mv_i,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  output int                    mismatch_count_o,
  output int                    pending_o
);

  localparam int     BlockLen  = SAMPLES_PER_BLOCK_DEF;
  localparam longint FullScale = ADC_FULL_SCALE;

  typedef struct packed {
    logic [SAMPLE_W-1:0] vbat_raw;
    logic [SAMPLE_W-1:0] current_raw;
    logic [SAMPLE_W-1:0] vbat_filtered_raw;
    logic [SAMPLE_W-1:0] current_filtered_raw;
    logic [MV_W-1:0]     vbat_mv;
    logic [MV_W-1:0]     current_mv;
    logic [MV_W-1:0]     vbat_filtered_mv;
    logic [MV_W-1:0]     current_filtered_mv;
  } block_result_t;

  block_result_t       block_result_q[$];
  logic [ALPHA_W-1:0]  alpha_q;
  logic [VREF_W-1:0]   vref_q;
  int unsigned         vbat_acc;
  int unsigned         current_acc;
  int unsigned         frames_in_block;
  logic [STATE_W-1:0]  vbat_ema;
  logic [STATE_W-1:0]  current_ema;
  logic                ema_loaded;

  // state plus floor of alpha * (avg<<16 - state) / 2^16, toward minus infinity
  function automatic logic [STATE_W-1:0] ema_step(input logic [STATE_W-1:0] st,
                                                  input logic [SAMPLE_W-1:0] avg);
    longint diff;
    longint nxt;
    diff = longint'({avg, 16'h0000}) - longint'(st);
    nxt  = longint'(st) + ((longint'(alpha_q) * diff) >>> FRAC_W);
    return nxt[STATE_W-1:0];
  endfunction

  function automatic logic [MV_W-1:0] scale_mv(input longint value, input longint full);
    longint q;
    q = (value * longint'(vref_q)) / full;
    return q[MV_W-1:0];
  endfunction

  task automatic check_field(input string field, input logic [15:0] want,
                             input logic [15:0] got);
    if (got !== want) begin
      $display("%0t %s: expected %0d, got %0d", $time, field, want, got);
      mismatch_count_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : monitor
    block_result_t       got;
    block_result_t       want;
    logic [SAMPLE_W-1:0] vavg;
    logic [SAMPLE_W-1:0] cavg;
    if (!rst_ni) begin
      block_result_q.delete();
      alpha_q          = ALPHA_RESET;
      vref_q           = VREF_RESET;
      vbat_acc         = 0;
      current_acc      = 0;
      frames_in_block  = 0;
      vbat_ema         = '0;
      current_ema      = '0;
      ema_loaded       = 1'b0;
      mismatch_count_o = 0;
      pending_o        = 0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          REG_ALPHA: alpha_q = cfg_data_i[ALPHA_W-1:0];
          REG_VREF:  vref_q  = cfg_data_i[VREF_W-1:0];
          default: ;
        endcase
      end

      if (out_valid_i && !out_stall_i) begin
        got = '{vbat_raw_i, current_raw_i, vbat_filtered_raw_i, current_filtered_raw_i,
                vbat_mv_i, current_mv_i, vbat_filtered_mv_i, current_filtered_mv_i};
        if (block_result_q.size() == 0) begin
          $display("%0t unexpected result: expected none, got %p", $time, got);
          mismatch_count_o++;
        end else begin
          want = block_result_q.pop_front();
          check_field("vbat_raw", want.vbat_raw, got.vbat_raw);
          check_field("current_raw", want.current_raw, got.current_raw);
          check_field("vbat_filtered_raw", want.vbat_filtered_raw, got.vbat_filtered_raw);
          check_field("current_filtered_raw", want.current_filtered_raw,
                      got.current_filtered_raw);
          check_field("vbat_mv", want.vbat_mv, got.vbat_mv);
          check_field("current_mv", want.current_mv, got.current_mv);
          check_field("vbat_filtered_mv", want.vbat_filtered_mv, got.vbat_filtered_mv);
          check_field("current_filtered_mv", want.current_filtered_mv,
                      got.current_filtered_mv);
        end
      end

      if (in_valid_i && !in_stall_i) begin
        vbat_acc        += vbat_sample_i;
        current_acc     += current_sample_i;
        frames_in_block += 1;
        if (frames_in_block == BlockLen) begin
          vavg = vbat_acc / BlockLen;
          cavg = current_acc / BlockLen;
          vbat_acc        = 0;
          current_acc     = 0;
          frames_in_block = 0;
          if (!ema_loaded) begin
            vbat_ema    = {vavg, 16'h0000};
            current_ema = {cavg, 16'h0000};
            ema_loaded  = 1'b1;
          end else begin
            vbat_ema    = ema_step(vbat_ema, vavg);
            current_ema = ema_step(current_ema, cavg);
          end
          want.vbat_raw             = vavg;
          want.current_raw          = cavg;
          want.vbat_filtered_raw    = vbat_ema[STATE_W-1:FRAC_W];
          want.current_filtered_raw = current_ema[STATE_W-1:FRAC_W];
          want.vbat_mv              = scale_mv(longint'(vavg), FullScale);
          want.current_mv           = scale_mv(longint'(cavg), FullScale);
          want.vbat_filtered_mv     = scale_mv(longint'(vbat_ema), FullScale << FRAC_W);
          want.current_filtered_mv  = scale_mv(longint'(current_ema), FullScale << FRAC_W);
          block_result_q.push_back(want);
        end
      end
      pending_o = block_result_q.size();
    end
  end

endmodule

// ===== dv/tb.sv =====
// tb: drives ADC frames and register writes into adc_oversample_ema_filter with random
// gaps and result stalls; reports the verdict. Depends on adcema_pkg, DUT, adcema_checker.
module tb;
  import adcema_pkg::*;

  localparam int BlockLen    = SAMPLES_PER_BLOCK_DEF;
  localparam int DrainCycles = 40;
  localparam int NumPhases   = 8;

  logic                  clk_i;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_stall_o;
  logic [SAMPLE_W-1:0]   vbat_sample_i;
  logic [SAMPLE_W-1:0]   current_sample_i;
  logic                  out_valid_o;
  logic                  out_stall_i;
  logic [SAMPLE_W-1:0]   vbat_raw_o;
  logic [SAMPLE_W-1:0]   current_raw_o;
  logic [SAMPLE_W-1:0]   vbat_filtered_raw_o;
  logic [SAMPLE_W-1:0]   current_filtered_raw_o;
  logic [MV_W-1:0]       vbat_mv_o;
  logic [MV_W-1:0]       current_mv_o;
  logic [MV_W-1:0]       vbat_filtered_mv_o;
  logic [MV_W-1:0]       current_filtered_mv_o;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;
  int                    mismatch_count;
  int                    pending;

  adc_oversample_ema_filter dut (.*);

  adcema_checker u_checker (
    .clk_i                  (clk_i),
    .rst_ni                 (rst_ni),
    .in_valid_i             (in_valid_i),
    .in_stall_i             (in_stall_o),
    .vbat_sample_i          (vbat_sample_i),
    .current_sample_i       (current_sample_i),
    .out_valid_i            (out_valid_o),
    .out_stall_i            (out_stall_i),
    .vbat_raw_i             (vbat_raw_o),
    .current_raw_i          (current_raw_o),
    .vbat_filtered_raw_i    (vbat_filtered_raw_o),
    .current_filtered_raw_i (current_filtered_raw_o),
    .vbat_mv_i              (vbat_mv_o),
    .current_mv_i           (current_mv_o),
    .vbat_filtered_mv_i     (vbat_filtered_mv_o),
    .current_filtered_mv_i  (current_filtered_mv_o),
    .cfg_we_i               (cfg_we_i),
    .cfg_idx_i              (cfg_idx_i),
    .cfg_data_i             (cfg_data_i),
    .mismatch_count_o       (mismatch_count),
    .pending_o              (pending)
  );

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #(20 * 1000000);
    $display("CHECK FAILED");
    $finish;
  end

  // result side: random stalls, one long hold-off so the block backs up
  initial begin : result_stall
    int iter;
    int hold;
    int r;
    out_stall_i <= 1'b0;
    @(posedge rst_ni);
    @(posedge clk_i);
    iter = 0;
    forever begin
      iter++;
      r = $urandom_range(0, 99);
      if (iter == 60)   hold = 400;
      else if (r < 50)  hold = 0;
      else if (r < 85)  hold = $urandom_range(1, 3);
      else if (r < 97)  hold = $urandom_range(4, 15);
      else              hold = $urandom_range(30, 90);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(posedge clk_i);
      end
      out_stall_i <= 1'b0;
      repeat ($urandom_range(0, 9) == 0 ? $urandom_range(20, 120) : $urandom_range(1, 6))
        @(posedge clk_i);
    end
  end

  function automatic int sender_gap(input bit steady);
    int r;
    r = $urandom_range(0, 99);
    if (steady || r < 55) return 0;
    if (r < 90)           return $urandom_range(1, 3);
    if (r < 98)           return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(input int mode, input int level);
    int v;
    case (mode)
      0:       v = $urandom_range(0, 4095);
      1:       v = $urandom_range(0, 1) ? 4095 : 0;
      2:       v = level + $urandom_range(0, 31);
      default: v = level;
    endcase
    return (v > 4095) ? 12'hFFF : v[SAMPLE_W-1:0];
  endfunction

  task automatic send_frame(input logic [SAMPLE_W-1:0] vbat, input logic [SAMPLE_W-1:0] cur,
                            input bit steady);
    int gap;
    gap = sender_gap(steady);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    vbat_sample_i    <= vbat;
    current_sample_i <= cur;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  task automatic drain_results();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [CFG_DATA_W-1:0] alpha,
                           input logic [CFG_DATA_W-1:0] vref);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= REG_ALPHA;
    cfg_data_i <= alpha;
    @(posedge clk_i);
    cfg_idx_i  <= REG_VREF;
    cfg_data_i <= vref;
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  initial begin : stimulus
    int                    frames_sent;
    int                    n;
    int                    vmode;
    int                    cmode;
    int                    vlevel;
    int                    clevel;
    bit                    steady;
    logic [CFG_DATA_W-1:0] alpha;
    logic [CFG_DATA_W-1:0] vref;
    rst_ni           <= 1'b0;
    in_valid_i       <= 1'b0;
    vbat_sample_i    <= '0;
    current_sample_i <= '0;
    cfg_we_i         <= 1'b0;
    cfg_idx_i        <= REG_ALPHA;
    cfg_data_i       <= '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // first block loads the filter; averages floor to full scale minus one and to zero
    for (int i = 0; i < BlockLen; i++)
      send_frame((i == BlockLen - 1) ? 12'd4094 : 12'd4095, (i == 0) ? 12'd15 : 12'd0,
                 1'b0);
    frames_sent = BlockLen;
    vmode  = 0;
    cmode  = 0;
    vlevel = 0;
    clevel = 0;
    steady = 1'b0;

    for (int phase = 0; phase < NumPhases; phase++) begin
      if (phase > 0) begin
        case (phase)
          1:       begin alpha = 16'hFFFF; vref = 16'd5000; end
          2:       begin alpha = 16'h0000; vref = 16'd8191; end
          3:       begin alpha = 16'h0001; vref = 16'd0;    end
          4:       begin alpha = 16'h8000; vref = 16'd4095; end
          5:       begin alpha = 16'hFFFE; vref = 16'd8191; end
          6:       begin alpha = $urandom_range(0, 65535); vref = $urandom_range(0, 5000); end
          default: begin alpha = $urandom_range(0, 65535); vref = $urandom_range(0, 65535); end
        endcase
        write_cfg(alpha, vref);
      end
      n = $urandom_range(200, 260);
      repeat (n) begin
        if (frames_sent % BlockLen == 0) begin
          vmode  = $urandom_range(0, 3);
          cmode  = $urandom_range(0, 3);
          vlevel = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 4095 : 0)
                                               : $urandom_range(0, 4095);
          clevel = ($urandom_range(0, 3) == 0) ? ($urandom_range(0, 1) ? 4095 : 0)
                                               : $urandom_range(0, 4095);
          steady = ($urandom_range(0, 4) == 0);
        end
        send_frame(draw_sample(vmode, vlevel), draw_sample(cmode, clevel), steady);
        frames_sent++;
      end
      drain_results();
    end

    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
